// File: src/tagged_bounds_shadow_checker_core_defines.svh
// ----------------------------------------------------------------------------
// Tagged bounds shadow checker assertion macros
// Shared property forms for the port-level checks of the core.
// ----------------------------------------------------------------------------
`ifndef TAGGED_BOUNDS_SHADOW_CHECKER_CORE_DEFINES_SVH
`define TAGGED_BOUNDS_SHADOW_CHECKER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tbsc_pkg.sv
// ----------------------------------------------------------------------------
// Tagged bounds shadow checker package
// Field widths, command and fault codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package tbsc_pkg;

   localparam int ADDR_W        = 64;
   localparam int LEN_W         = 17;
   localparam int TAG_W         = 8;
   localparam int CMD_W         = 2;
   localparam int KIND_W        = 3;
   localparam int WBASE_W       = 48;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 64;
   localparam int GRANULE_BITS  = 4;
   localparam int TAG_SHIFT     = 56;
   localparam int GRAN_W        = TAG_SHIFT - GRANULE_BITS;
   localparam int CNT_W         = LEN_W - GRANULE_BITS + 1;
   localparam int SHADOW_ENTRIES_DEFAULT = 4096;

   localparam logic [TAG_W-1:0] TAG_LOW_RESET  = 8'd171;
   localparam logic [TAG_W-1:0] TAG_HIGH_RESET = 8'd255;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_BASE  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHECK_ENABLE = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TAG_LOW      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TAG_HIGH     = 8'd3;

   typedef enum logic [CMD_W-1:0] {
      OP_TAG   = 2'd0,
      OP_CHECK = 2'd1,
      OP_FREE  = 2'd2,
      OP_GEN   = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      FK_NONE          = 3'd0,
      FK_BOUNDS        = 3'd1,
      FK_FREE_TAG      = 3'd2,
      FK_FREE_INTERIOR = 3'd3,
      FK_WINDOW        = 3'd4
   } fault_kind_type;

   typedef struct packed {
      logic           load;
      logic           clr_wr;
      logic           rd;
      logic           tag_step;
      logic           prev_step;
      logic           finish;
      logic           gen_tag;
      fault_kind_type kind;
   } tbsc_ctl_type;

   typedef struct packed {
      op_type op;
      logic   clr_last;
      logic   count_zero;
      logic   last_granule;
      logic   win_ok;
      logic   chk_active;
      logic   free_active;
      logic   has_prev;
      logic   bounds_fault;
      logic   tag_match;
      logic   oor_seen;
      logic   out_free;
   } tbsc_sts_type;

endpackage

// File: src/tbsc_channels.sv
// ----------------------------------------------------------------------------
// Tagged bounds shadow checker channels
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbsc_req_if;
   import tbsc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ADDR_W-1:0] address;
   logic [LEN_W-1:0]  length;
   logic [TAG_W-1:0]  tag;

   modport source (output valid, cmd, address, length, tag, input ready);
   modport sink   (input valid, cmd, address, length, tag, output ready);
endinterface

interface tbsc_rsp_if;
   import tbsc_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] tagged_pointer;
   logic [TAG_W-1:0]  tag_out;
   logic              fault;
   logic [KIND_W-1:0] fault_kind;

   modport source (output valid, tagged_pointer, tag_out, fault, fault_kind, input ready);
   modport sink   (input valid, tagged_pointer, tag_out, fault, fault_kind, output ready);
endinterface

interface tbsc_csr_if;
   import tbsc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/tbsc_ram.sv
// ----------------------------------------------------------------------------
// Tagged bounds shadow checker RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tbsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: src/tbsc_ctrl.sv
// ----------------------------------------------------------------------------
// Tagged bounds shadow checker controller
// Sequences the clearing pass, region tagging, checks and tag generation.
// ----------------------------------------------------------------------------
module tbsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tbsc_pkg::tbsc_sts_type sts,
   output tbsc_pkg::tbsc_ctl_type ctl
);
   import tbsc_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_START  = 8'b0000_0100,
      ST_TAG    = 8'b0000_1000,
      ST_CHECK  = 8'b0001_0000,
      ST_PREV   = 8'b0010_0000,
      ST_PCHECK = 8'b0100_0000,
      ST_FIN    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      ctl       = '0;
      ctl.kind  = FK_NONE;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            case (sts.op)
               OP_TAG: begin
                  if (!sts.count_zero) begin
                     state_in = ST_TAG;
                  end else if (sts.out_free) begin
                     ctl.finish = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
               OP_CHECK, OP_FREE: begin
                  if ((sts.op == OP_CHECK) ? sts.chk_active : sts.free_active) begin
                     if (sts.win_ok) begin
                        ctl.rd   = 1'b1;
                        state_in = ST_CHECK;
                     end else if (sts.out_free) begin
                        ctl.finish = 1'b1;
                        ctl.kind   = FK_WINDOW;
                        state_in   = ST_IDLE;
                     end
                  end else if (sts.out_free) begin
                     ctl.finish = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
               default: begin
                  if (sts.out_free) begin
                     ctl.finish  = 1'b1;
                     ctl.gen_tag = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
            endcase
         end
         ST_TAG: begin
            ctl.tag_step = 1'b1;
            if (sts.last_granule) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (sts.out_free) begin
               ctl.finish = 1'b1;
               ctl.kind   = sts.oor_seen ? FK_WINDOW : FK_NONE;
               state_in   = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (sts.op == OP_CHECK) begin
               if (sts.out_free) begin
                  ctl.finish = 1'b1;
                  ctl.kind   = sts.bounds_fault ? FK_BOUNDS : FK_NONE;
                  state_in   = ST_IDLE;
               end
            end else if (sts.tag_match && sts.has_prev) begin
               ctl.prev_step = 1'b1;
               state_in      = ST_PREV;
            end else if (sts.out_free) begin
               ctl.finish = 1'b1;
               ctl.kind   = sts.tag_match ? FK_NONE : FK_FREE_TAG;
               state_in   = ST_IDLE;
            end
         end
         ST_PREV: begin
            if (sts.win_ok) begin
               ctl.rd   = 1'b1;
               state_in = ST_PCHECK;
            end else if (sts.out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_PCHECK: begin
            if (sts.out_free) begin
               ctl.finish = 1'b1;
               ctl.kind   = sts.tag_match ? FK_FREE_INTERIOR : FK_NONE;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: src/tbsc_datapath.sv
// ----------------------------------------------------------------------------
// Tagged bounds shadow checker datapath
// Shadow store, window mapping, bound and tag compares, and result register.
// ----------------------------------------------------------------------------
module tbsc_datapath #(
   parameter int SHADOW_ENTRIES = tbsc_pkg::SHADOW_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tbsc_pkg::tbsc_ctl_type            ctl,
   output tbsc_pkg::tbsc_sts_type            sts,
   input  logic [tbsc_pkg::CMD_W-1:0]        req_cmd,
   input  logic [tbsc_pkg::ADDR_W-1:0]       req_address,
   input  logic [tbsc_pkg::LEN_W-1:0]        req_length,
   input  logic [tbsc_pkg::TAG_W-1:0]        req_tag,
   input  logic                              csr_valid,
   input  logic [tbsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tbsc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [tbsc_pkg::ADDR_W-1:0]       rsp_tagged_pointer,
   output logic [tbsc_pkg::TAG_W-1:0]        rsp_tag_out,
   output logic                              rsp_fault,
   output logic [tbsc_pkg::KIND_W-1:0]       rsp_fault_kind
);
   import tbsc_pkg::*;

   localparam int IDX_W  = $clog2(SHADOW_ENTRIES);
   localparam int BASE_W = WBASE_W - GRANULE_BITS;
   localparam int CUR_W  = GRAN_W + 1;
   localparam int DIFF_W = CUR_W + 1;

   op_type              op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [ADDR_W-1:0]   sum_ff, sum_in;
   logic                chk_act_ff, chk_act_in;
   logic                free_act_ff, free_act_in;
   logic                has_prev_ff, has_prev_in;
   logic [CUR_W-1:0]    cur_ff, cur_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic                oor_ff, oor_in;
   logic [IDX_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [TAG_W-1:0]    next_tag_ff, next_tag_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic                chk_en_ff, chk_en_in;
   logic [TAG_W-1:0]    tag_low_ff, tag_low_in;
   logic [TAG_W-1:0]    tag_high_ff, tag_high_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_tp_ff, rsp_tp_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic                rsp_fault_ff, rsp_fault_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;

   logic [DIFF_W-1:0]   diff;
   logic                win_ok;
   logic [IDX_W-1:0]    win_idx;
   logic [LEN_W:0]      len_round;
   logic [ADDR_W-1:0]   meta;
   logic [ADDR_W-1:0]   bound_diff;
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [ADDR_W-1:0]   ram_wdata;
   logic [ADDR_W-1:0]   ram_rdata;
   logic                out_free;

   // The window entry is the granule index less the granule index of the base.
   assign diff    = {1'b0, cur_ff} - DIFF_W'(base_ff);
   assign win_ok  = !diff[DIFF_W-1] && (diff[CUR_W-1:0] < CUR_W'(SHADOW_ENTRIES));
   assign win_idx = diff[IDX_W-1:0];

   assign len_round  = {1'b0, req_length} + (LEN_W+1)'(15);
   assign meta       = (tag_ff == '0) ? '0 : (sum_ff | {tag_ff, {TAG_SHIFT{1'b0}}});
   assign bound_diff = ram_rdata - sum_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign ram_we    = ctl.clr_wr || (ctl.tag_step && win_ok);
   assign ram_waddr = ctl.clr_wr ? clr_idx_ff : win_idx;
   assign ram_wdata = ctl.clr_wr ? '0 : meta;

   tbsc_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (SHADOW_ENTRIES)
   ) u_shadow (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ctl.rd),
      .raddr (win_idx),
      .rdata (ram_rdata)
   );

   always_comb begin
      sts.op           = op_ff;
      sts.clr_last     = (clr_idx_ff == IDX_W'(SHADOW_ENTRIES - 1));
      sts.count_zero   = (remain_ff == '0);
      sts.last_granule = (remain_ff == CNT_W'(1));
      sts.win_ok       = win_ok;
      sts.chk_active   = chk_act_ff;
      sts.free_active  = free_act_ff;
      sts.has_prev     = has_prev_ff;
      sts.bounds_fault = (bound_diff[ADDR_W-1:ADDR_W-16] != '0);
      sts.tag_match    = (ram_rdata[ADDR_W-1:TAG_SHIFT] == addr_ff[ADDR_W-1:TAG_SHIFT]);
      sts.oor_seen     = oor_ff;
      sts.out_free     = out_free;
   end

   always_comb begin
      op_in       = op_ff;
      addr_in     = addr_ff;
      tag_in      = tag_ff;
      sum_in      = sum_ff;
      chk_act_in  = chk_act_ff;
      free_act_in = free_act_ff;
      has_prev_in = has_prev_ff;
      cur_in      = cur_ff;
      remain_in   = remain_ff;
      oor_in      = oor_ff;
      clr_idx_in  = clr_idx_ff;
      next_tag_in = next_tag_ff;
      base_in     = base_ff;
      chk_en_in   = chk_en_ff;
      tag_low_in  = tag_low_ff;
      tag_high_in = tag_high_ff;
      if (ctl.load) begin
         op_in       = op_type'(req_cmd);
         addr_in     = req_address;
         tag_in      = req_tag;
         sum_in      = req_address + ADDR_W'(req_length) - ADDR_W'(1);
         chk_act_in  = chk_en_ff && (req_length != '0)
                       && (req_address[ADDR_W-1:TAG_SHIFT] != '0);
         free_act_in = (req_address[ADDR_W-1:TAG_SHIFT] != '0);
         has_prev_in = (req_address[TAG_SHIFT-1:GRANULE_BITS] != '0);
         cur_in      = {1'b0, req_address[TAG_SHIFT-1:GRANULE_BITS]};
         remain_in   = len_round[LEN_W:GRANULE_BITS];
         oor_in      = 1'b0;
      end
      if (ctl.tag_step) begin
         cur_in    = cur_ff + CUR_W'(1);
         remain_in = remain_ff - CNT_W'(1);
         if (!win_ok) begin
            oor_in = 1'b1;
         end
      end
      if (ctl.prev_step) begin
         cur_in = cur_ff - CUR_W'(1);
      end
      if (ctl.clr_wr) begin
         clr_idx_in = clr_idx_ff + IDX_W'(1);
      end
      if (ctl.gen_tag) begin
         next_tag_in = (next_tag_ff >= tag_high_ff) ? tag_low_ff : next_tag_ff + TAG_W'(1);
      end
      if (csr_valid) begin
         case (csr_index)
            REG_WINDOW_BASE:  base_in     = csr_data[WBASE_W-1:GRANULE_BITS];
            REG_CHECK_ENABLE: chk_en_in   = csr_data[0];
            REG_TAG_LOW:      tag_low_in  = csr_data[TAG_W-1:0];
            REG_TAG_HIGH:     tag_high_in = csr_data[TAG_W-1:0];
            default:          base_in     = base_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_tp_in    = rsp_tp_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_tp_in    = (op_ff == OP_TAG) ?
                        {tag_ff, addr_ff[TAG_SHIFT-1:0]} : '0;
         rsp_tag_in   = (op_ff == OP_GEN) ? next_tag_ff : '0;
         rsp_fault_in = (ctl.kind != FK_NONE);
         rsp_kind_in  = ctl.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff   <= '0;
         next_tag_ff  <= TAG_LOW_RESET;
         base_ff      <= '0;
         chk_en_ff    <= 1'b1;
         tag_low_ff   <= TAG_LOW_RESET;
         tag_high_ff  <= TAG_HIGH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_idx_ff   <= clr_idx_in;
         next_tag_ff  <= next_tag_in;
         base_ff      <= base_in;
         chk_en_ff    <= chk_en_in;
         tag_low_ff   <= tag_low_in;
         tag_high_ff  <= tag_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      tag_ff       <= tag_in;
      sum_ff       <= sum_in;
      chk_act_ff   <= chk_act_in;
      free_act_ff  <= free_act_in;
      has_prev_ff  <= has_prev_in;
      cur_ff       <= cur_in;
      remain_ff    <= remain_in;
      oor_ff       <= oor_in;
      rsp_tp_ff    <= rsp_tp_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tagged_pointer = rsp_tp_ff;
   assign rsp_tag_out        = rsp_tag_ff;
   assign rsp_fault          = rsp_fault_ff;
   assign rsp_fault_kind     = rsp_kind_ff;
endmodule

// File: src/tagged_bounds_shadow_checker_core.sv
// Tag generation, empty regions, out-of-window checks and unchecked commands are answered
// from the start state; an access check answers after one registered shadow RAM read, a
// free check after one or two reads, and tagging after a step through each granule.
// One request is in flight at a time; the next is taken once the controller is back in
// idle, which it enters as the response is registered. After reset the whole shadow
// store is cleared with req_ch.ready low.
// ----------------------------------------------------------------------------
// Tagged bounds shadow checker core
// Shadow bounds and tag metadata unit with a windowed shadow store.
// ----------------------------------------------------------------------------
module tagged_bounds_shadow_checker_core #(
   parameter int SHADOW_ENTRIES = tbsc_pkg::SHADOW_ENTRIES_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   tbsc_req_if.sink    req_ch,
   tbsc_rsp_if.source  rsp_ch,
   tbsc_csr_if.sink    csr_ch
);
   import tbsc_pkg::*;

   tbsc_ctl_type ctl;
   tbsc_sts_type sts;

   assign csr_ch.ready = 1'b1;

   tbsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   tbsc_datapath #(
      .SHADOW_ENTRIES (SHADOW_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_cmd            (req_ch.cmd),
      .req_address        (req_ch.address),
      .req_length         (req_ch.length),
      .req_tag            (req_ch.tag),
      .csr_valid          (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_tagged_pointer (rsp_ch.tagged_pointer),
      .rsp_tag_out        (rsp_ch.tag_out),
      .rsp_fault          (rsp_ch.fault),
      .rsp_fault_kind     (rsp_ch.fault_kind)
   );
endmodule

// File: src/tbsc_checker.sv
// ----------------------------------------------------------------------------
// Tagged bounds shadow checker port checks
// Port-level properties of the core, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "tagged_bounds_shadow_checker_core_defines.svh"

module tbsc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tbsc_pkg::ADDR_W-1:0]      rsp_tagged_pointer,
   input logic [tbsc_pkg::TAG_W-1:0]       rsp_tag_out,
   input logic                             rsp_fault,
   input logic [tbsc_pkg::KIND_W-1:0]      rsp_fault_kind
);
   import tbsc_pkg::*;

   `TBSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tagged_pointer) && $stable(rsp_tag_out) && $stable(rsp_fault_kind), "Stalled response changed")
   `TBSC_ASSERT_NOW(a_fault_flag, clock, reset, rsp_valid, rsp_fault == (rsp_fault_kind != FK_NONE), "Fault flag disagrees with fault kind")
   `TBSC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "Request taken while another is in flight")
   `TBSC_ASSERT_NOW(a_check_payload, clock, reset, rsp_valid && (rsp_fault_kind == FK_BOUNDS || rsp_fault_kind == FK_FREE_TAG || rsp_fault_kind == FK_FREE_INTERIOR), rsp_tagged_pointer == '0 && rsp_tag_out == '0, "Check fault carries pointer or tag")
   `TBSC_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && !req_ready, "Core not quiet after reset")
endmodule

bind tagged_bounds_shadow_checker_core tbsc_checker u_tbsc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_tagged_pointer (rsp_ch.tagged_pointer),
   .rsp_tag_out        (rsp_ch.tag_out),
   .rsp_fault          (rsp_ch.fault),
   .rsp_fault_kind     (rsp_ch.fault_kind)
);
